### rtl/oll_pkg.sv
// Shared constants, codes and types of the ordered list engine.
package oll_pkg;

  localparam int DEPTH_DEF = 256;

  localparam int DATA_W   = 32;
  localparam int CMD_W    = 3;
  localparam int POS_W    = 16;
  localparam int STATUS_W = 2;
  localparam int IDX_W    = 9;

  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_INSERT     = 3'd4;
  localparam logic [CMD_W-1:0] CMD_REMOVE     = 3'd5;
  localparam logic [CMD_W-1:0] CMD_FIND       = 3'd6;
  localparam logic [CMD_W-1:0] CMD_QUERY      = 3'd7;

  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_SH,
    ST_PUT,
    ST_REM_V,
    ST_REM_SH,
    ST_FIND,
    ST_FIN,
    ST_FIN_F,
    ST_FIN_B,
    ST_DONE
  } state_t;

endpackage

### rtl/oll_if.sv
// Handshake channels of the ordered list engine: command items and result items.
interface oll_cmd_if;
  logic                                 valid;
  logic                                 ready;
  logic [oll_pkg::CMD_W-1:0]            cmd;
  logic [oll_pkg::POS_W-1:0]            position;
  logic signed [oll_pkg::DATA_W-1:0]    value_in;

  modport source (output valid, cmd, position, value_in, input ready);
  modport sink   (input valid, cmd, position, value_in, output ready);
endinterface

interface oll_res_if;
  logic                                 valid;
  logic                                 ready;
  logic [oll_pkg::STATUS_W-1:0]         status;
  logic signed [oll_pkg::DATA_W-1:0]    value_out;
  logic [oll_pkg::IDX_W-1:0]            found_at;
  logic [oll_pkg::IDX_W-1:0]            count;
  logic                                 is_empty;
  logic signed [oll_pkg::DATA_W-1:0]    front_value;
  logic signed [oll_pkg::DATA_W-1:0]    back_value;

  modport source (output valid, status, value_out, found_at, count, is_empty,
                  front_value, back_value, input ready);
  modport sink   (input valid, status, value_out, found_at, count, is_empty,
                  front_value, back_value, output ready);
endinterface

### rtl/ordered_list_engine_top.sv
// Top level of the ordered list engine: sequencer, entry memory and result register.
//
// The engine keeps an ordered list of up to DEPTH signed 32-bit values in a
// single-port-read entry memory, front at address 0. It takes one command item
// at a time and is not ready while that item is being worked on. Every entry
// that has to move or be compared passes through the memory's one read port, one
// entry a cycle. A pop at the back moves nothing. Every command ends by reading
// the front and back entries back from the memory; when the list is empty after
// the command those two reads are skipped. A finished result sits in an output
// register, so the next command item is accepted while the result waits; only a
// second finished result stalls until the first has been taken. No clearing pass
// is needed after reset: the count alone decides which entries are live.
module ordered_list_engine_top #(
  parameter int DEPTH = oll_pkg::DEPTH_DEF
) (
  input logic      clk,
  input logic      rst_n,
  oll_cmd_if.sink  in_cmd,
  oll_res_if.source out_res
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = (CW > oll_pkg::POS_W) ? CW : oll_pkg::POS_W;

  oll_pkg::state_t state_r, state_nxt;

  logic [oll_pkg::CMD_W-1:0]     cmd_r, cmd_nxt;
  logic [oll_pkg::DATA_W-1:0]    val_r, val_nxt;
  logic [AW-1:0]                 ptr_r, ptr_nxt;
  logic [AW-1:0]                 stop_r, stop_nxt;
  logic [CW-1:0]                 count_r, count_nxt;
  logic [oll_pkg::STATUS_W-1:0]  status_r, status_nxt;
  logic [oll_pkg::DATA_W-1:0]    vout_r, vout_nxt;
  logic [CW-1:0]                 found_r, found_nxt;
  logic [oll_pkg::DATA_W-1:0]    front_r, front_nxt;
  logic [oll_pkg::DATA_W-1:0]    back_r, back_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          out_load;

  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic [oll_pkg::DATA_W-1:0]    ram_wdata;
  logic                          ram_re;
  logic [AW-1:0]                 ram_raddr;
  logic [oll_pkg::DATA_W-1:0]    ram_rdata;

  logic [AW-1:0]                 last_w;
  logic [CW-1:0]                 ins_pos_w;
  logic                          is_full_w;
  logic                          pos_out_w;
  logic                          is_pop_w;
  logic [CW+8:0]                 count_ext_w;
  logic [CW+8:0]                 found_ext_w;

  oll_ram #(
    .WIDTH (oll_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Address of the last live entry; only meaningful while the list is not empty.
  assign last_w    = AW'(count_r - CW'(1));
  assign is_full_w = (count_r == CW'(DEPTH));
  assign pos_out_w = (EW'(in_cmd.position) >= EW'(count_r));
  assign is_pop_w  = (cmd_r == oll_pkg::CMD_POP_FRONT) || (cmd_r == oll_pkg::CMD_POP_BACK);

  // Insertion point: pushes go to either end, an insert past the end goes to the back.
  always_comb begin
    if (in_cmd.cmd == oll_pkg::CMD_PUSH_FRONT) begin
      ins_pos_w = '0;
    end else if (in_cmd.cmd == oll_pkg::CMD_PUSH_BACK || pos_out_w) begin
      ins_pos_w = count_r;
    end else begin
      ins_pos_w = CW'(in_cmd.position);
    end
  end

  assign in_cmd.ready = (state_r == oll_pkg::ST_IDLE);

  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    val_nxt    = val_r;
    ptr_nxt    = ptr_r;
    stop_nxt   = stop_r;
    count_nxt  = count_r;
    status_nxt = status_r;
    vout_nxt   = vout_r;
    found_nxt  = found_r;
    front_nxt  = front_r;
    back_nxt   = back_r;
    out_load   = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = AW'(ptr_r + 1'b1);
    ram_wdata  = ram_rdata;
    ram_re     = 1'b0;
    ram_raddr  = ptr_r;

    unique case (state_r)
      oll_pkg::ST_IDLE: begin
        if (in_cmd.valid) begin
          cmd_nxt    = in_cmd.cmd;
          val_nxt    = in_cmd.value_in;
          status_nxt = oll_pkg::STAT_OK;
          vout_nxt   = '0;
          found_nxt  = '0;
          state_nxt  = oll_pkg::ST_FIN;
          unique case (in_cmd.cmd)
            oll_pkg::CMD_PUSH_FRONT, oll_pkg::CMD_PUSH_BACK, oll_pkg::CMD_INSERT: begin
              if (is_full_w) begin
                status_nxt = oll_pkg::STAT_FULL;
              end else begin
                stop_nxt = AW'(ins_pos_w);
                if (ins_pos_w == count_r) begin
                  state_nxt = oll_pkg::ST_PUT;
                end else begin
                  // Shift from the back towards the insertion point.
                  ptr_nxt   = last_w;
                  ram_re    = 1'b1;
                  ram_raddr = last_w;
                  state_nxt = oll_pkg::ST_INS_SH;
                end
              end
            end
            oll_pkg::CMD_POP_FRONT, oll_pkg::CMD_POP_BACK: begin
              if (count_r == '0) begin
                status_nxt = oll_pkg::STAT_EMPTY;
              end else begin
                ptr_nxt   = (in_cmd.cmd == oll_pkg::CMD_POP_FRONT) ? '0 : last_w;
                ram_re    = 1'b1;
                ram_raddr = (in_cmd.cmd == oll_pkg::CMD_POP_FRONT) ? '0 : last_w;
                state_nxt = oll_pkg::ST_REM_V;
              end
            end
            oll_pkg::CMD_REMOVE: begin
              if (pos_out_w) begin
                status_nxt = oll_pkg::STAT_RANGE;
              end else begin
                ptr_nxt   = AW'(in_cmd.position);
                ram_re    = 1'b1;
                ram_raddr = AW'(in_cmd.position);
                state_nxt = oll_pkg::ST_REM_V;
              end
            end
            oll_pkg::CMD_FIND: begin
              found_nxt = count_r;
              if (count_r != '0) begin
                ptr_nxt   = '0;
                ram_re    = 1'b1;
                ram_raddr = '0;
                state_nxt = oll_pkg::ST_FIND;
              end
            end
            default: begin
              state_nxt = oll_pkg::ST_FIN;
            end
          endcase
        end
      end

      oll_pkg::ST_INS_SH: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(ptr_r + 1'b1);
        ram_wdata = ram_rdata;
        if (ptr_r == stop_r) begin
          state_nxt = oll_pkg::ST_PUT;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = AW'(ptr_r - 1'b1);
          ptr_nxt   = AW'(ptr_r - 1'b1);
        end
      end

      oll_pkg::ST_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = stop_r;
        ram_wdata = val_r;
        count_nxt = CW'(count_r + 1'b1);
        state_nxt = oll_pkg::ST_FIN;
      end

      oll_pkg::ST_REM_V: begin
        if (is_pop_w) begin
          vout_nxt = ram_rdata;
        end
        if (ptr_r == last_w) begin
          count_nxt = CW'(count_r - 1'b1);
          state_nxt = oll_pkg::ST_FIN;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = AW'(ptr_r + 1'b1);
          ptr_nxt   = AW'(ptr_r + 1'b1);
          state_nxt = oll_pkg::ST_REM_SH;
        end
      end

      oll_pkg::ST_REM_SH: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(ptr_r - 1'b1);
        ram_wdata = ram_rdata;
        if (ptr_r == last_w) begin
          count_nxt = CW'(count_r - 1'b1);
          state_nxt = oll_pkg::ST_FIN;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = AW'(ptr_r + 1'b1);
          ptr_nxt   = AW'(ptr_r + 1'b1);
        end
      end

      oll_pkg::ST_FIND: begin
        if (ram_rdata == val_r) begin
          found_nxt = CW'(ptr_r);
          state_nxt = oll_pkg::ST_FIN;
        end else if (ptr_r == last_w) begin
          state_nxt = oll_pkg::ST_FIN;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = AW'(ptr_r + 1'b1);
          ptr_nxt   = AW'(ptr_r + 1'b1);
        end
      end

      oll_pkg::ST_FIN: begin
        if (count_r == '0) begin
          front_nxt = '0;
          back_nxt  = '0;
          state_nxt = oll_pkg::ST_DONE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = '0;
          state_nxt = oll_pkg::ST_FIN_F;
        end
      end

      oll_pkg::ST_FIN_F: begin
        front_nxt = ram_rdata;
        ram_re    = 1'b1;
        ram_raddr = last_w;
        state_nxt = oll_pkg::ST_FIN_B;
      end

      oll_pkg::ST_FIN_B: begin
        back_nxt  = ram_rdata;
        state_nxt = oll_pkg::ST_DONE;
      end

      oll_pkg::ST_DONE: begin
        // Wait here only if the previous result has not yet been taken.
        if (!out_valid_r || out_res.ready) begin
          out_load  = 1'b1;
          state_nxt = oll_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = oll_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_res.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Counts are reported in their low nine bits.
  assign count_ext_w = {9'b0, count_r};
  assign found_ext_w = {9'b0, found_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= oll_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    val_r    <= val_nxt;
    ptr_r    <= ptr_nxt;
    stop_r   <= stop_nxt;
    status_r <= status_nxt;
    vout_r   <= vout_nxt;
    found_r  <= found_nxt;
    front_r  <= front_nxt;
    back_r   <= back_nxt;
    if (out_load) begin
      out_res.status      <= status_r;
      out_res.value_out   <= vout_r;
      out_res.found_at    <= found_ext_w[8:0];
      out_res.count       <= count_ext_w[8:0];
      out_res.is_empty    <= (count_r == '0);
      out_res.front_value <= front_r;
      out_res.back_value  <= back_r;
    end
  end

  assign out_res.valid = out_valid_r;

  // The list never holds more than DEPTH entries.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count exceeds depth");

  // Once an item is accepted the engine stays busy for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_cmd.valid && in_cmd.ready) |=> !in_cmd.ready)
    else $error("ready did not drop after accepting an item");

  // A result is never overwritten before it has been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_res.ready))
    else $error("result register overwritten while still waiting");

  // The empty flag agrees with the reported count, checked only while DEPTH is below 512.
  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid |-> (out_res.is_empty == (out_res.count == '0) || DEPTH > 511))
    else $error("empty flag disagrees with count");

  // A full status is only reported while the list is actually full.
  a_full_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == oll_pkg::ST_FIN && status_r == oll_pkg::STAT_FULL) |-> is_full_w)
    else $error("full status given while the list is not full");

endmodule

### rtl/oll_ram.sv
// Generic single-write, single-read RAM with registered read data.
module oll_ram #(
  parameter int WIDTH = oll_pkg::DATA_W,
  parameter int DEPTH = oll_pkg::DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench of the ordered list engine: directed table, then random phases.
`timescale 1ns / 100ps

module tb_top;

  // The engine is built with its default depth, so the shadow list uses the same bound.
  localparam int LIST_DEPTH = oll_pkg::DEPTH_DEF;
  // Least number of random command items after the directed table.
  localparam int RAND_ITEMS = 1650;
  // Cycles allowed after the last result for any stray result item to show up.
  // The longest command walks the whole list and then reads front and back.
  localparam int TAIL_CYCLES = LIST_DEPTH + 40;
  // Hard stop. Each item of the slowest correct run may cost a sender gap, a
  // full-list walk and a receiver stall; the limit is several times the total.
  localparam int CYCLE_LIMIT = 2_000_000;

  // One expected result item, laid out as the result channel carries it.
  typedef struct packed {
    logic [oll_pkg::STATUS_W-1:0]      status;
    logic signed [oll_pkg::DATA_W-1:0] value_out;
    logic [oll_pkg::IDX_W-1:0]         found_at;
    logic [oll_pkg::IDX_W-1:0]         count;
    logic                              is_empty;
    logic signed [oll_pkg::DATA_W-1:0] front_value;
    logic signed [oll_pkg::DATA_W-1:0] back_value;
  } list_result_t;

  // One row of the directed table. Where known_res is set, the expected result
  // is written out by hand; otherwise the shadow list supplies it.
  typedef struct {
    logic [oll_pkg::CMD_W-1:0]         cmd;
    logic [oll_pkg::POS_W-1:0]         position;
    logic signed [oll_pkg::DATA_W-1:0] value_in;
    bit                                known_res;
    list_result_t                      res;
  } stim_row_t;

  // Random phases steer the list length: growing, shrinking, churning in the
  // middle, or filling right up to the depth and then working at the full mark.
  typedef enum int {PH_GROW, PH_SHRINK, PH_MIXED, PH_FILL} phase_t;

  logic clk = 1'b0;
  logic rst_n;

  oll_cmd_if cmd_ch ();
  oll_res_if res_ch ();

  ordered_list_engine_top dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_cmd  (cmd_ch),
    .out_res (res_ch)
  );

  // Shadow copy of the stored list, front at index 0.
  logic signed [oll_pkg::DATA_W-1:0] shadow_list [$];
  // Results still owed by the engine, oldest first.
  list_result_t pending_res [$];
  stim_row_t    directed_rows [$];
  list_result_t got_res;

  int  errors = 0;
  int  cycles = 0;
  // When clear, neither side inserts gaps, so commands and results run back to back.
  bit  idle_on = 1'b1;

  always #5 clk = ~clk;

  // Reset is asserted at the start and never asserted again.
  initial begin
    rst_n <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
  end

  // The run is stopped here if the engine hangs or a handshake never completes.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Applies one command to the shadow list and returns the result item that
  // the engine ought to produce for it.
  function automatic list_result_t apply_list_cmd(
      input logic [oll_pkg::CMD_W-1:0] c,
      input logic [oll_pkg::POS_W-1:0] p,
      input logic signed [oll_pkg::DATA_W-1:0] v);
    list_result_t r;
    int n;
    int i;
    bit hit;
    r = '0;
    n = shadow_list.size();
    case (c)
      oll_pkg::CMD_PUSH_FRONT, oll_pkg::CMD_PUSH_BACK, oll_pkg::CMD_INSERT: begin
        // An insert at index 0 goes to the front; one at or past the count goes to the back.
        if (n >= LIST_DEPTH)
          r.status = oll_pkg::STAT_FULL;
        else if (c == oll_pkg::CMD_PUSH_FRONT || (c == oll_pkg::CMD_INSERT && p == 0))
          shadow_list.insert(0, v);
        else if (c == oll_pkg::CMD_PUSH_BACK || int'(p) >= n)
          shadow_list.insert(n, v);
        else
          shadow_list.insert(int'(p), v);
      end
      oll_pkg::CMD_POP_FRONT: begin
        if (n == 0)
          r.status = oll_pkg::STAT_EMPTY;
        else begin
          r.value_out = shadow_list[0];
          shadow_list.delete(0);
        end
      end
      oll_pkg::CMD_POP_BACK: begin
        if (n == 0)
          r.status = oll_pkg::STAT_EMPTY;
        else begin
          r.value_out = shadow_list[n-1];
          shadow_list.delete(n - 1);
        end
      end
      oll_pkg::CMD_REMOVE: begin
        if (int'(p) >= n)
          r.status = oll_pkg::STAT_RANGE;
        else
          shadow_list.delete(int'(p));
      end
      oll_pkg::CMD_FIND: begin
        // The first matching position wins; no match reports the count.
        r.found_at = n[oll_pkg::IDX_W-1:0];
        hit = 1'b0;
        for (i = 0; i < n; i++) begin
          if (!hit && shadow_list[i] == v) begin
            r.found_at = i[oll_pkg::IDX_W-1:0];
            hit = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    n = shadow_list.size();
    r.count    = n[oll_pkg::IDX_W-1:0];
    r.is_empty = (n == 0);
    if (n != 0) begin
      r.front_value = shadow_list[0];
      r.back_value  = shadow_list[n-1];
    end
    return r;
  endfunction

  function automatic void add_row(input logic [oll_pkg::CMD_W-1:0] c,
                                  input logic [oll_pkg::POS_W-1:0] p,
                                  input logic signed [oll_pkg::DATA_W-1:0] v,
                                  input bit known, input list_result_t res);
    stim_row_t row;
    row.cmd       = c;
    row.position  = p;
    row.value_in  = v;
    row.known_res = known;
    row.res       = res;
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  function automatic void check_field(input string name,
                                      input logic [oll_pkg::DATA_W-1:0] want,
                                      input logic [oll_pkg::DATA_W-1:0] got);
    if (got !== want) begin
      errors++;
      $error("%s: expected %h, got %h", name, want, got);
    end
  endfunction

  // Presents one command item after a random gap (none while idle_on is clear) and
  // waits for the engine to take it. The expected result is worked out at the moment
  // of acceptance, so the shadow list always matches the engine's order of work.
  task automatic send_cmd(input logic [oll_pkg::CMD_W-1:0] c,
                          input logic [oll_pkg::POS_W-1:0] p,
                          input logic signed [oll_pkg::DATA_W-1:0] v, input bit known,
                          input list_result_t known_val);
    int gap;
    list_result_t r;
    gap = idle_on ? $urandom_range(0, 9) : 0;
    repeat (gap) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid    <= 1'b1;
    cmd_ch.cmd      <= c;
    cmd_ch.position <= p;
    cmd_ch.value_in <= v;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    r = apply_list_cmd(c, p, v);
    pending_res.insert(pending_res.size(), known ? known_val : r);
  endtask

  // Holds the command channel quiet until every owed result item has come back.
  task automatic wait_for_results();
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_res.size() != 0) @(posedge clk);
  endtask

  // Draws a random command whose mix depends on the phase. Positions favour the
  // boundaries (front, back, last entry, far past the end) and values favour a
  // small pool, so that duplicates exist and finds hit often.
  task automatic gen_cmd(input phase_t ph, output logic [oll_pkg::CMD_W-1:0] c,
                         output logic [oll_pkg::POS_W-1:0] p,
                         output logic signed [oll_pkg::DATA_W-1:0] v);
    int unsigned wt [0:7];
    int unsigned total;
    int unsigned roll;
    int n;
    int k;
    n = shadow_list.size();
    // Weights in command order: push front, push back, pop front, pop back,
    // insert, remove, find, query.
    case (ph)
      PH_GROW:   wt = '{15, 25, 5, 5, 25, 8, 12, 5};
      PH_SHRINK: wt = '{5, 8, 20, 20, 5, 25, 12, 5};
      PH_FILL:   wt = '{5, 70, 0, 0, 15, 0, 5, 5};
      default:   wt = '{12, 12, 12, 12, 14, 14, 16, 8};
    endcase
    total = 0;
    for (k = 0; k < 8; k++) total += wt[k];
    roll = $urandom_range(0, total - 1);
    c = oll_pkg::CMD_QUERY;
    for (k = 7; k >= 0; k--) begin
      total -= wt[k];
      if (roll >= total && wt[k] != 0 && roll < total + wt[k])
        c = k[oll_pkg::CMD_W-1:0];
    end

    case ($urandom_range(0, 9))
      0:       p = '0;
      1:       p = n[oll_pkg::POS_W-1:0];
      2:       p = (n > 0) ? oll_pkg::POS_W'(n - 1) : '0;
      3:       p = '1;
      4:       p = oll_pkg::POS_W'($urandom_range(0, 65535));
      default: p = oll_pkg::POS_W'($urandom_range(0, n));
    endcase

    roll = $urandom_range(0, 99);
    if (c == oll_pkg::CMD_FIND && n > 0 && roll < 50)
      v = shadow_list[$urandom_range(0, n - 1)];
    else if (roll < 65)
      v = $urandom;
    else if (roll < 85)
      v = $signed($urandom_range(0, 4)) - 2;
    else begin
      case ($urandom_range(0, 3))
        0:       v = 32'sh7FFF_FFFF;
        1:       v = 32'sh8000_0000;
        2:       v = '0;
        default: v = '1;
      endcase
    end
  endtask

  // Result side: after each result item taken, ready is dropped for a random
  // number of cycles, so stalls land at every point of the engine's work.
  initial begin
    int stall;
    res_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = idle_on ? $urandom_range(0, 9) : 0;
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      @(posedge clk);
      while (!res_ch.valid) @(posedge clk);
    end
  end

  // Every result item taken is compared field by field with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (pending_res.size() == 0) begin
        errors++;
        $error("result item arrived while none was expected");
      end else begin
        got_res = pending_res[0];
        pending_res.delete(0);
        check_field("status", oll_pkg::DATA_W'(got_res.status),
                    oll_pkg::DATA_W'(res_ch.status));
        check_field("value_out", got_res.value_out, res_ch.value_out);
        check_field("found_at", oll_pkg::DATA_W'(got_res.found_at),
                    oll_pkg::DATA_W'(res_ch.found_at));
        check_field("count", oll_pkg::DATA_W'(got_res.count),
                    oll_pkg::DATA_W'(res_ch.count));
        check_field("is_empty", oll_pkg::DATA_W'(got_res.is_empty),
                    oll_pkg::DATA_W'(res_ch.is_empty));
        check_field("front_value", got_res.front_value, res_ch.front_value);
        check_field("back_value", got_res.back_value, res_ch.back_value);
      end
    end
  end

  // Command side: the directed table first, then the random phases.
  initial begin
    logic [oll_pkg::CMD_W-1:0]         c;
    logic [oll_pkg::POS_W-1:0]         p;
    logic signed [oll_pkg::DATA_W-1:0] v;
    phase_t                            ph;
    int                                items;
    int                                phase_no;
    int                                len;
    int                                r;

    cmd_ch.valid    <= 1'b0;
    cmd_ch.cmd      <= oll_pkg::CMD_QUERY;
    cmd_ch.position <= '0;
    cmd_ch.value_in <= '0;

    // On the empty list right after reset: a query, both pops, a remove and a
    // find all leave the list alone. The pops report empty, the remove reports
    // an index out of range and the find reports position 0.
    add_row(oll_pkg::CMD_QUERY, 16'h0000, 32'sh0, 1'b1,
            '{oll_pkg::STAT_OK, 32'sh0, 9'd0, 9'd0, 1'b1, 32'sh0, 32'sh0});
    add_row(oll_pkg::CMD_POP_FRONT, 16'hFFFF, 32'shFFFF_FFFF, 1'b1,
            '{oll_pkg::STAT_EMPTY, 32'sh0, 9'd0, 9'd0, 1'b1, 32'sh0, 32'sh0});
    add_row(oll_pkg::CMD_POP_BACK, 16'h0000, 32'sh0, 1'b1,
            '{oll_pkg::STAT_EMPTY, 32'sh0, 9'd0, 9'd0, 1'b1, 32'sh0, 32'sh0});
    add_row(oll_pkg::CMD_REMOVE, 16'h0000, 32'sh0, 1'b1,
            '{oll_pkg::STAT_RANGE, 32'sh0, 9'd0, 9'd0, 1'b1, 32'sh0, 32'sh0});
    add_row(oll_pkg::CMD_FIND, 16'hFFFF, 32'sh5, 1'b1,
            '{oll_pkg::STAT_OK, 32'sh0, 9'd0, 9'd0, 1'b1, 32'sh0, 32'sh0});
    // The two extreme values, one at each end.
    add_row(oll_pkg::CMD_PUSH_BACK, 16'h0000, 32'sh7FFF_FFFF, 1'b1,
            '{oll_pkg::STAT_OK, 32'sh0, 9'd0, 9'd1, 1'b0, 32'sh7FFF_FFFF,
              32'sh7FFF_FFFF});
    add_row(oll_pkg::CMD_PUSH_FRONT, 16'hFFFF, 32'sh8000_0000, 1'b1,
            '{oll_pkg::STAT_OK, 32'sh0, 9'd0, 9'd2, 1'b0, 32'sh8000_0000,
              32'sh7FFF_FFFF});
    // Inserts at the front, far past the end, in the middle and exactly at the count.
    add_row(oll_pkg::CMD_INSERT, 16'h0000, 32'shFFFF_FFFF, 1'b0, '0);
    add_row(oll_pkg::CMD_INSERT, 16'hFFFF, 32'sh0, 1'b0, '0);
    add_row(oll_pkg::CMD_INSERT, 16'h0002, 32'sh0000_3039, 1'b0, '0);
    add_row(oll_pkg::CMD_INSERT, 16'h0005, 32'sh7, 1'b0, '0);
    // Finds: two hits in the middle and a miss, which reports the count.
    add_row(oll_pkg::CMD_FIND, 16'h0000, 32'sh0000_3039, 1'b0, '0);
    add_row(oll_pkg::CMD_FIND, 16'hAAAA, 32'sh7FFF_FFFF, 1'b0, '0);
    add_row(oll_pkg::CMD_FIND, 16'h5555, 32'sh2A, 1'b0, '0);
    // Removes: far past the end and at the count are rejected; then front,
    // middle and last entry.
    add_row(oll_pkg::CMD_REMOVE, 16'hFFFF, 32'sh0, 1'b0, '0);
    add_row(oll_pkg::CMD_REMOVE, 16'h0006, 32'sh0, 1'b0, '0);
    add_row(oll_pkg::CMD_REMOVE, 16'h0000, 32'sh0, 1'b0, '0);
    add_row(oll_pkg::CMD_REMOVE, 16'h0001, 32'sh0, 1'b0, '0);
    add_row(oll_pkg::CMD_REMOVE, 16'h0003, 32'sh0, 1'b0, '0);
    add_row(oll_pkg::CMD_POP_FRONT, 16'h1234, 32'sh1234_5678, 1'b0, '0);
    add_row(oll_pkg::CMD_POP_BACK, 16'h0000, 32'sh0, 1'b0, '0);
    add_row(oll_pkg::CMD_QUERY, 16'hFFFF, 32'shFFFF_FFFF, 1'b0, '0);
    add_row(oll_pkg::CMD_PUSH_BACK, 16'hFFFF, 32'sh5A5A_5A5A, 1'b0, '0);
    // Two pops at the back bring the list down to empty again.
    add_row(oll_pkg::CMD_POP_BACK, 16'h0000, 32'sh0, 1'b0, '0);
    add_row(oll_pkg::CMD_POP_BACK, 16'h0000, 32'sh0, 1'b0, '0);

    @(posedge clk);
    while (!rst_n) @(posedge clk);

    foreach (directed_rows[i])
      send_cmd(directed_rows[i].cmd, directed_rows[i].position, directed_rows[i].value_in,
               directed_rows[i].known_res, directed_rows[i].res);

    // Random phases. The first one always fills the list, so the full-list
    // rejections are certain to be exercised; later fills come now and then.
    items    = 0;
    phase_no = 0;
    while (items < RAND_ITEMS) begin
      r = $urandom_range(0, 7);
      ph = (phase_no == 0 || r == 0) ? PH_FILL : phase_t'($urandom_range(0, 2));
      idle_on = ($urandom_range(0, 3) != 0);
      // Before a fill, and now and then elsewhere, the sender lets the engine
      // drain completely so that a command meets a fully idle block.
      if (ph == PH_FILL || $urandom_range(0, 4) == 0)
        wait_for_results();
      if (ph == PH_FILL) begin
        while (shadow_list.size() < LIST_DEPTH) begin
          gen_cmd(PH_FILL, c, p, v);
          send_cmd(c, p, v, 1'b0, '0);
          items++;
        end
        // Hover at the full mark: pushes and inserts bounce off until a pop or
        // a remove makes room.
        ph  = PH_MIXED;
        len = $urandom_range(10, 30);
      end else begin
        len = $urandom_range(20, 80);
      end
      repeat (len) begin
        gen_cmd(ph, c, p, v);
        send_cmd(c, p, v, 1'b0, '0);
        items++;
      end
      phase_no++;
    end

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (pending_res.size() != 0) begin
      errors++;
      $error("%0d expected result items never arrived", pending_res.size());
    end
    if (errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

### files.f
rtl/oll_pkg.sv
rtl/oll_if.sv
rtl/oll_ram.sv
rtl/ordered_list_engine_top.sv
tb/sv/tb_top.sv
